// ===== design/qrs_pkg.sv =====
package qrs_pkg;

    // Fixed field widths
    localparam int FEATURE_W       = 19;
    localparam int RUN_W           = 8;
    localparam int WARM_W          = 16;
    localparam int WARM_CNT_W      = WARM_W + 1;
    localparam int DATA_W          = 32;
    localparam int ADDR_W          = 3;
    localparam int REG_IDX_W       = ADDR_W - 2;

    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [FEATURE_W-1:0] FEATURE_MAX = {FEATURE_W{1'b1}};

    // Register map, word index (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_PEAK_RUN = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_WARMUP   = 1'b1;

    localparam logic [RUN_W-1:0]  PEAK_RUN_RESET = 8'd8;
    localparam logic [WARM_W-1:0] WARMUP_RESET   = 16'd256;

endpackage

// ===== design/qrs_feature.sv =====
module qrs_feature #(
    parameter int SAMPLE_BITS = qrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0]  x0,
    input  logic signed [SAMPLE_BITS-1:0]  x1,
    input  logic signed [SAMPLE_BITS-1:0]  x2,
    input  logic signed [SAMPLE_BITS-1:0]  x3,
    input  logic signed [SAMPLE_BITS-1:0]  x4,
    output logic [qrs_pkg::FEATURE_W-1:0]  feature
);
    import qrs_pkg::*;

    localparam int DW    = SAMPLE_BITS + 1;
    localparam int D2W   = SAMPLE_BITS + 2;
    localparam int SUM_W = SAMPLE_BITS + 3;
    localparam int EXT_W = (SUM_W > FEATURE_W) ? SUM_W : FEATURE_W + 1;

    logic signed [DW-1:0]  d20;
    logic signed [DW-1:0]  d31;
    logic signed [DW-1:0]  d42;
    logic signed [D2W-1:0] dd;
    logic [DW-1:0]         a20;
    logic [DW-1:0]         a31;
    logic [DW-1:0]         a42;
    logic [D2W-1:0]        add;
    logic [EXT_W-1:0]      sum;

    // First differences, sign-extended by one bit so they cannot overflow
    assign d20 = {x2[SAMPLE_BITS-1], x2} - {x0[SAMPLE_BITS-1], x0};
    assign d31 = {x3[SAMPLE_BITS-1], x3} - {x1[SAMPLE_BITS-1], x1};
    assign d42 = {x4[SAMPLE_BITS-1], x4} - {x2[SAMPLE_BITS-1], x2};

    // Second difference x0 - 2*x2 + x4
    assign dd = {{2{x0[SAMPLE_BITS-1]}}, x0} + {{2{x4[SAMPLE_BITS-1]}}, x4}
              - {x2[SAMPLE_BITS-1], x2, 1'b0};

    assign a20 = d20[DW-1]  ? (~d20 + 1'b1) : d20;
    assign a31 = d31[DW-1]  ? (~d31 + 1'b1) : d31;
    assign a42 = d42[DW-1]  ? (~d42 + 1'b1) : d42;
    assign add = dd[D2W-1]  ? (~dd + 1'b1)  : dd;

    assign sum = EXT_W'(a20) + EXT_W'({a31, 1'b0}) + EXT_W'(a42) + EXT_W'(add);

    // Clamp to the feature range
    assign feature = (sum > EXT_W'(FEATURE_MAX)) ? FEATURE_MAX : sum[FEATURE_W-1:0];

endmodule

// ===== design/qrs_peak_detector.sv =====
// QRS peak detector, Ahlstrom-Tompkins style. Each accepted item is one signed ECG
// sample; together with the four previous samples it forms a five-sample window
// whose feature |x2-x0| + 2|x3-x1| + |x4-x2| + |x0-2x2+x4| (clamped to 19 bits) is
// reported with every result. The block tracks the largest feature seen since
// reset; the upper threshold is 0.8 of that peak and the lower one 0.1 of it, both
// tested exactly in integer form. The first warmup_length+1 samples only learn the
// peak; after that detecting is high, a feature at or above the upper threshold
// arms the detector, and a run of peak_run_length samples at or above the lower
// threshold raises beat on the sample that completes the run. Every sample gives
// exactly one result. Throughput is one item per clock unless the result stalls;
// each sample passes through the input register and then the result register,
// with all window, threshold and run logic sitting between the two. A stalled
// result holds both stages, so the input stalls only when both registers are full.
// Registers (APB, byte address): 0x0 peak_run_length (8 bits, reset 8, zero acts
// as one), 0x4 warmup_length (16 bits, reset 256). Write them only while idle.
module qrs_peak_detector #(
    parameter int SAMPLE_BITS = qrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qrs_pkg::ADDR_W-1:0]        paddr,
    input  logic [qrs_pkg::DATA_W-1:0]        pwdata,
    output logic [qrs_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    // sample channel
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              beat,
    output logic [qrs_pkg::FEATURE_W-1:0]     feature,
    output logic                              detecting
);
    import qrs_pkg::*;

    // configuration registers
    logic [RUN_W-1:0]     peak_run_reg;
    logic [WARM_W-1:0]    warmup_len_reg;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    // input stage
    logic                          a_valid_reg;
    logic signed [SAMPLE_BITS-1:0] a_sample_reg;
    logic                          a_load;
    logic                          b_adv;

    // detector state
    logic signed [SAMPLE_BITS-1:0] hist_reg [4];
    logic [FEATURE_W-1:0]          peak_reg;
    logic [FEATURE_W-1:0]          peak_next;
    logic                          armed_reg;
    logic                          armed_next;
    logic [RUN_W-1:0]              run_reg;
    logic [RUN_W-1:0]              run_next;
    logic [WARM_CNT_W-1:0]         warm_reg;
    logic [WARM_CNT_W-1:0]         warm_next;

    // result stage
    logic                 result_valid_reg;
    logic                 beat_reg;
    logic                 beat_next;
    logic                 det_reg;
    logic                 det_next;
    logic [FEATURE_W-1:0] feature_reg;

    logic [FEATURE_W-1:0] feat;
    logic [FEATURE_W+2:0] feat_x5;
    logic [FEATURE_W+2:0] peak_x4;
    logic [FEATURE_W+3:0] feat_x10;
    logic                 above_upper;
    logic                 above_lower;
    logic [RUN_W-1:0]     need;
    logic                 armed_tmp;

    //------------------------------------------------------------------
    // Configuration port: zero-wait, index taken from the word address
    //------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_run_reg   <= PEAK_RUN_RESET;
            warmup_len_reg <= WARMUP_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PEAK_RUN: peak_run_reg   <= pwdata[RUN_W-1:0];
                REG_WARMUP:   warmup_len_reg <= pwdata[WARM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PEAK_RUN: prdata = DATA_W'(peak_run_reg);
            REG_WARMUP:   prdata = DATA_W'(warmup_len_reg);
            default:      prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Handshake: the result stage advances whenever the input stage holds
    // a sample and the result register is empty or being taken; the input stage refills in the same cycle.
    //------------------------------------------------------------------
    assign b_adv        = a_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = a_valid_reg && !b_adv;
    assign a_load       = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_load)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (b_adv)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_sample_reg <= sample;
        end
    end

    //------------------------------------------------------------------
    // Feature over the window: oldest history entry up to the new sample
    //------------------------------------------------------------------
    qrs_feature #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_feature (
        .x0      (hist_reg[0]),
        .x1      (hist_reg[1]),
        .x2      (hist_reg[2]),
        .x3      (hist_reg[3]),
        .x4      (a_sample_reg),
        .feature (feat)
    );

    //------------------------------------------------------------------
    // Thresholds and run logic. The peak is updated before the tests:
    // upper is 5*F >= 4*peak, lower is 10*F >= peak.
    //------------------------------------------------------------------
    assign peak_next   = (feat > peak_reg) ? feat : peak_reg;
    assign feat_x5     = (FEATURE_W+3)'(feat) + {feat, 2'b00};
    assign peak_x4     = (FEATURE_W+3)'({peak_next, 2'b00});
    assign feat_x10    = {feat_x5, 1'b0};
    assign above_upper = feat_x5 >= peak_x4;
    assign above_lower = feat_x10 >= (FEATURE_W+4)'(peak_next);
    // a zero run length acts as one
    assign need        = (peak_run_reg == '0) ? RUN_W'(1) : peak_run_reg;

    always_comb
    begin
        warm_next = warm_reg;
        run_next  = run_reg;
        armed_tmp = armed_reg;
        beat_next = 1'b0;
        det_next  = 1'b0;
        if (warm_reg <= WARM_CNT_W'(warmup_len_reg))
        begin
            // still learning: count up, saturating one past the length
            warm_next = warm_reg + 1'b1;
        end
        else
        begin
            det_next  = 1'b1;
            armed_tmp = armed_reg || above_upper;
            if (armed_tmp && above_lower)
            begin
                run_next = run_reg + 1'b1;
            end
            else
            begin
                run_next  = '0;
                armed_tmp = 1'b0;
            end
            if (armed_tmp && run_next >= need)
            begin
                // beat: drop the run and disarm
                beat_next = 1'b1;
                run_next  = '0;
                armed_tmp = 1'b0;
            end
        end
        armed_next = armed_tmp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hist_reg[i] <= '0;
            end
            peak_reg  <= '0;
            armed_reg <= 1'b0;
            run_reg   <= '0;
            warm_reg  <= '0;
        end
        else if (b_adv)
        begin
            // advance the delay line, newest sample at the top
            for (int i = 0; i < 3; i++)
            begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[3] <= a_sample_reg;
            peak_reg    <= peak_next;
            armed_reg   <= armed_next;
            run_reg     <= run_next;
            warm_reg    <= warm_next;
        end
    end

    //------------------------------------------------------------------
    // Result register
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            beat_reg    <= beat_next;
            det_reg     <= det_next;
            feature_reg <= feat;
        end
    end

    assign result_valid = result_valid_reg;
    assign beat         = beat_reg;
    assign detecting    = det_reg;
    assign feature      = feature_reg;

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    // the tracked peak never falls
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("feature peak decreased");

    // a reported feature never exceeds the peak it was tested against
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> feature_reg <= peak_reg)
        else $error("result feature above tracked peak");

    // a beat leaves the detector disarmed with an empty run
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && beat_next) |=> (!armed_reg && run_reg == '0))
        else $error("detector not cleared after beat");

    // a beat only comes out of an active detector
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && beat_reg) |-> det_reg)
        else $error("beat outside detection");

    // the input side stalls only with both stages full
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (a_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled with room in the pipeline");

endmodule
